// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define EFG_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checks that a condition implies an expectation in the same cycle.
`define EFG_ASSERT_IMPL(name, cond, conseq, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

`endif

// ===== src/efg_pkg.sv =====
package efg_pkg;

   // Default depth of the queue between the front and the back.
   localparam int QueueDepth = 8;
   // One root bit per square root stage, one quotient bit per divide stage.
   localparam int SqrtSteps = 32;
   localparam int DivSteps = 31;
   localparam logic [31:0] LengthMax = 32'hFFFF_FFFF;
   localparam logic signed [31:0] NormalOne = 32'sd1073741824;

   // Classified edge, as handed from the front to the back.
   typedef struct packed {
      logic [31:0] mid_x;
      logic [31:0] mid_y;
      logic [31:0] adx;
      logic [31:0] ady;
      logic [31:0] arx;
      logic [31:0] ary;
      logic [30:0] an;
      logic [30:0] bn;
      logic        dx_neg;
      logic        dy_pos;
      logic        n1;
      logic        n2;
      logic        owner;
   } item_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [31:0] rem;
      logic        q;
   } div_type;

   // Everything one back stage carries.
   typedef struct packed {
      item_type    item;
      logic [63:0] a2;
      logic [63:0] b2;
      logic [63:0] na2;
      logic [63:0] nb2;
      logic [63:0] m1;
      logic [63:0] m2;
      logic        ovf;
      logic        flip;
      sqrt_type    s_sq;
      sqrt_type    n_sq;
      logic [31:0] l_norm;
      logic [31:0] rem_a;
      logic [31:0] rem_b;
      logic [30:0] dvd_a;
      logic [30:0] dvd_b;
      logic [30:0] q_a;
      logic [30:0] q_b;
   } stage_type;

   // Position of the highest set bit, zero for a zero word.
   function automatic logic [4:0] lead_one(logic [31:0] m);
      logic [4:0] pos;
      pos = '0;
      for (int i = 0; i < 32; i++) begin
         if (m[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

   // Moves a value so that a leading one at lead lands on bit 30.
   function automatic logic [30:0] norm_shift(logic [31:0] a, logic [4:0] lead);
      logic [30:0] r;
      if (lead == 5'd31) begin
         r = a[31:1];
      end else begin
         r = 31'(a << (5'd30 - lead));
      end
      return r;
   endfunction

   // One step of the bit-pair square root; k counts from the top pair.
   function automatic sqrt_type sqrt_step(sqrt_type cur, int unsigned k);
      logic [63:0] bit_v;
      logic [63:0] trial;
      sqrt_type    nxt;
      bit_v = 64'd1 << (62 - 2 * k);
      trial = cur.root + bit_v;
      if (cur.rem >= trial) begin
         nxt.rem = cur.rem - trial;
         nxt.root = (cur.root >> 1) + bit_v;
      end else begin
         nxt.rem = cur.rem;
         nxt.root = cur.root >> 1;
      end
      return nxt;
   endfunction

   // One restoring divide step; the remainder stays below the divisor.
   function automatic div_type div_step(logic [31:0] rem, logic in_bit, logic [31:0] dsr);
      logic [32:0] shifted;
      div_type     r;
      shifted = {rem, in_bit};
      if (shifted >= {1'b0, dsr}) begin
         r.rem = 32'(shifted - {1'b0, dsr});
         r.q = 1'b1;
      end else begin
         r.rem = shifted[31:0];
         r.q = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== src/efg_req_if.sv =====
interface efg_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic signed [31:0] owner_center_x;
   logic signed [31:0] owner_center_y;
   logic               has_owner;

   modport source (
      output valid, start_x, start_y, end_x, end_y, owner_center_x, owner_center_y,
             has_owner,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, end_x, end_y, owner_center_x, owner_center_y,
             has_owner,
      output ready
   );
endinterface

// ===== src/efg_rsp_if.sv =====
interface efg_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        edge_length;
   logic signed [31:0] mid_x;
   logic signed [31:0] mid_y;
   logic signed [31:0] normal_x;
   logic signed [31:0] normal_y;
   logic               degenerate;

   modport source (
      output valid, edge_length, mid_x, mid_y, normal_x, normal_y, degenerate,
      input  ready
   );
   modport sink (
      input  valid, edge_length, mid_x, mid_y, normal_x, normal_y, degenerate,
      output ready
   );
endinterface

// ===== src/efg_front.sv =====
module efg_front #(
   parameter int QUEUE_DEPTH = efg_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   efg_req_if.sink            req_if,
   input  logic               pop,
   output logic               push_valid,
   output efg_pkg::item_type  push_item
);
   localparam int OccWidth = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] sumx;
      logic signed [32:0] sumy;
      logic [31:0]        cx;
      logic [31:0]        cy;
      logic               owner;
   } f1_type;

   typedef struct packed {
      logic [31:0] adx;
      logic [31:0] ady;
      logic [31:0] mx;
      logic [31:0] my;
      logic [31:0] cx;
      logic [31:0] cy;
      logic        dx_neg;
      logic        dy_pos;
      logic        owner;
   } f2_type;

   typedef struct packed {
      logic [31:0]        adx;
      logic [31:0]        ady;
      logic [31:0]        mx;
      logic [31:0]        my;
      logic signed [32:0] rx;
      logic signed [32:0] ry;
      logic [31:0]        m;
      logic               dx_neg;
      logic               dy_pos;
      logic               owner;
   } f3_type;

   typedef struct packed {
      logic [31:0] adx;
      logic [31:0] ady;
      logic [31:0] mx;
      logic [31:0] my;
      logic [31:0] arx;
      logic [31:0] ary;
      logic [4:0]  lead;
      logic        rx_neg;
      logic        ry_neg;
      logic        dx_neg;
      logic        dy_pos;
      logic        owner;
   } f4_type;

   logic [OccWidth-1:0] occ_ff, occ_in;
   logic [4:0]          valid_ff, valid_in;
   logic                accept;
   f1_type              f1_ff, f1_in;
   f2_type              f2_ff, f2_in;
   f3_type              f3_ff, f3_in;
   f4_type              f4_ff, f4_in;
   efg_pkg::item_type   f5_ff, f5_in;

   // Credits cover every request in the front stages and in the queue.
   assign req_if.ready = occ_ff < OccWidth'(QUEUE_DEPTH);
   assign accept = req_if.valid && req_if.ready;
   assign occ_in = occ_ff + OccWidth'(accept) - OccWidth'(pop);
   assign valid_in = {valid_ff[3:0], accept};

   // Differences and endpoint sums.
   always_comb begin
      f1_in.dx = {req_if.end_x[31], req_if.end_x} - {req_if.start_x[31], req_if.start_x};
      f1_in.dy = {req_if.end_y[31], req_if.end_y} - {req_if.start_y[31], req_if.start_y};
      f1_in.sumx = {req_if.end_x[31], req_if.end_x} + {req_if.start_x[31], req_if.start_x};
      f1_in.sumy = {req_if.end_y[31], req_if.end_y} + {req_if.start_y[31], req_if.start_y};
      f1_in.cx = req_if.owner_center_x;
      f1_in.cy = req_if.owner_center_y;
      f1_in.owner = req_if.has_owner;
   end

   // Magnitudes, signs and the floored midpoint.
   always_comb begin
      f2_in.adx = f1_ff.dx[32] ? 32'(-f1_ff.dx) : f1_ff.dx[31:0];
      f2_in.ady = f1_ff.dy[32] ? 32'(-f1_ff.dy) : f1_ff.dy[31:0];
      f2_in.mx = f1_ff.sumx[32:1];
      f2_in.my = f1_ff.sumy[32:1];
      f2_in.cx = f1_ff.cx;
      f2_in.cy = f1_ff.cy;
      f2_in.dx_neg = f1_ff.dx[32];
      f2_in.dy_pos = !f1_ff.dy[32] && (f1_ff.dy != '0);
      f2_in.owner = f1_ff.owner;
   end

   // Offset from the owner centroid and the larger magnitude.
   always_comb begin
      f3_in.adx = f2_ff.adx;
      f3_in.ady = f2_ff.ady;
      f3_in.mx = f2_ff.mx;
      f3_in.my = f2_ff.my;
      f3_in.rx = {f2_ff.mx[31], f2_ff.mx} - {f2_ff.cx[31], f2_ff.cx};
      f3_in.ry = {f2_ff.my[31], f2_ff.my} - {f2_ff.cy[31], f2_ff.cy};
      f3_in.m = (f2_ff.adx >= f2_ff.ady) ? f2_ff.adx : f2_ff.ady;
      f3_in.dx_neg = f2_ff.dx_neg;
      f3_in.dy_pos = f2_ff.dy_pos;
      f3_in.owner = f2_ff.owner;
   end

   // Offset magnitudes and the leading one of the larger magnitude.
   always_comb begin
      f4_in.adx = f3_ff.adx;
      f4_in.ady = f3_ff.ady;
      f4_in.mx = f3_ff.mx;
      f4_in.my = f3_ff.my;
      f4_in.arx = f3_ff.rx[32] ? 32'(-f3_ff.rx) : f3_ff.rx[31:0];
      f4_in.ary = f3_ff.ry[32] ? 32'(-f3_ff.ry) : f3_ff.ry[31:0];
      f4_in.lead = efg_pkg::lead_one(f3_ff.m);
      f4_in.rx_neg = f3_ff.rx[32];
      f4_in.ry_neg = f3_ff.ry[32];
      f4_in.dx_neg = f3_ff.dx_neg;
      f4_in.dy_pos = f3_ff.dy_pos;
      f4_in.owner = f3_ff.owner;
   end

   // Normalized components and the signs of the two orientation products.
   always_comb begin
      f5_in.mid_x = f4_ff.mx;
      f5_in.mid_y = f4_ff.my;
      f5_in.adx = f4_ff.adx;
      f5_in.ady = f4_ff.ady;
      f5_in.arx = f4_ff.arx;
      f5_in.ary = f4_ff.ary;
      f5_in.an = efg_pkg::norm_shift(f4_ff.adx, f4_ff.lead);
      f5_in.bn = efg_pkg::norm_shift(f4_ff.ady, f4_ff.lead);
      f5_in.dx_neg = f4_ff.dx_neg;
      f5_in.dy_pos = f4_ff.dy_pos;
      f5_in.n1 = (f4_ff.ady != '0) && (f4_ff.arx != '0) && (f4_ff.dy_pos != f4_ff.rx_neg);
      f5_in.n2 = (f4_ff.adx != '0) && (f4_ff.ary != '0) && (f4_ff.dx_neg != f4_ff.ry_neg);
      f5_in.owner = f4_ff.owner;
   end

   assign push_valid = valid_ff[4];
   assign push_item = f5_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         valid_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         valid_ff <= valid_in;
      end
   end

   // Payload stages run freely; credits keep the queue from overflowing.
   always_ff @(posedge clock) begin
      f1_ff <= f1_in;
      f2_ff <= f2_in;
      f3_ff <= f3_in;
      f4_ff <= f4_in;
      f5_ff <= f5_in;
   end

endmodule

// ===== src/efg_queue.sv =====
`include "assert_macros.svh"

module efg_queue #(
   parameter int DEPTH = efg_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  efg_pkg::item_type  push_item,
   input  logic               pop,
   output logic               head_valid,
   output efg_pkg::item_type  head_item
);
   localparam int PtrWidth = $clog2(DEPTH);
   localparam int CntWidth = $clog2(DEPTH + 1);

   efg_pkg::item_type   mem_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign head_valid = count_ff != '0;
   assign head_item = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntWidth'(push_valid) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `EFG_ASSERT_IMPL(a_no_overflow, push_valid && !pop,
      count_ff < CntWidth'(DEPTH), "queue overflow")
   `EFG_ASSERT_IMPL(a_no_underflow, pop, count_ff != '0, "queue underflow")

endmodule

// ===== src/efg_back.sv =====
`include "assert_macros.svh"

module efg_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  efg_pkg::item_type  head_item,
   input  logic [15:0]        csr_limit,
   output logic               pop,
   efg_rsp_if.source          rsp_if
);
   localparam int SqFirst = 3;
   localparam int SqLast = SqFirst + efg_pkg::SqrtSteps - 1;
   localparam int DivInit = SqLast + 1;
   localparam int DivFirst = DivInit + 1;
   localparam int Last = DivFirst + efg_pkg::DivSteps - 1;
   localparam int NStage = Last + 1;

   typedef struct packed {
      logic [31:0]        edge_length;
      logic signed [31:0] mid_x;
      logic signed [31:0] mid_y;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic               degenerate;
   } out_type;

   efg_pkg::stage_type stage_ff [NStage];
   efg_pkg::stage_type stage_in [NStage];
   logic [NStage-1:0]  valid_ff, valid_in;
   logic               out_valid_ff;
   out_type            out_ff, out_in;
   logic               adv;

   // The whole chain moves unless a finished result is held by the sink.
   assign adv = !out_valid_ff || rsp_if.ready;
   assign pop = adv && head_valid;
   assign valid_in = {valid_ff[NStage-2:0], pop};

   // Take the queue head.
   always_comb begin
      stage_in[0] = '0;
      stage_in[0].item = head_item;
   end

   // Squares and orientation products, one multiplier each.
   always_comb begin
      stage_in[1] = stage_ff[0];
      stage_in[1].a2 = 64'(stage_ff[0].item.adx) * 64'(stage_ff[0].item.adx);
      stage_in[1].b2 = 64'(stage_ff[0].item.ady) * 64'(stage_ff[0].item.ady);
      stage_in[1].na2 = 64'(stage_ff[0].item.an) * 64'(stage_ff[0].item.an);
      stage_in[1].nb2 = 64'(stage_ff[0].item.bn) * 64'(stage_ff[0].item.bn);
      stage_in[1].m1 = 64'(stage_ff[0].item.ady) * 64'(stage_ff[0].item.arx);
      stage_in[1].m2 = 64'(stage_ff[0].item.adx) * 64'(stage_ff[0].item.ary);
   end

   // Sums of squares and the flip decision.
   always_comb begin
      logic neg;
      stage_in[2] = stage_ff[1];
      {stage_in[2].ovf, stage_in[2].s_sq.rem} = 65'(stage_ff[1].a2) + 65'(stage_ff[1].b2);
      stage_in[2].s_sq.root = '0;
      stage_in[2].n_sq.rem = stage_ff[1].na2 + stage_ff[1].nb2;
      stage_in[2].n_sq.root = '0;
      if (stage_ff[1].item.n1 == stage_ff[1].item.n2) begin
         neg = stage_ff[1].item.n1 && ((stage_ff[1].m1 != '0) || (stage_ff[1].m2 != '0));
      end else if (stage_ff[1].item.n1) begin
         neg = stage_ff[1].m1 > stage_ff[1].m2;
      end else begin
         neg = stage_ff[1].m2 > stage_ff[1].m1;
      end
      stage_in[2].flip = stage_ff[1].item.owner && neg;
   end

   // Square roots of the raw and the normalized sums, one bit per stage.
   for (genvar k = 0; k < efg_pkg::SqrtSteps; k++) begin : g_sqrt
      always_comb begin
         stage_in[SqFirst + k] = stage_ff[SqFirst + k - 1];
         stage_in[SqFirst + k].s_sq = efg_pkg::sqrt_step(stage_ff[SqFirst + k - 1].s_sq, k);
         stage_in[SqFirst + k].n_sq = efg_pkg::sqrt_step(stage_ff[SqFirst + k - 1].n_sq, k);
      end
   end

   // Rounded dividends; their upper part is already below the divisor.
   always_comb begin
      logic [61:0] num_a;
      logic [61:0] num_b;
      logic [31:0] l_val;
      l_val = stage_ff[SqLast].n_sq.root[31:0];
      num_a = 62'({stage_ff[SqLast].item.an, 30'b0}) + 62'(l_val[31:1]);
      num_b = 62'({stage_ff[SqLast].item.bn, 30'b0}) + 62'(l_val[31:1]);
      stage_in[DivInit] = stage_ff[SqLast];
      stage_in[DivInit].l_norm = l_val;
      stage_in[DivInit].rem_a = 32'(num_a[61:31]);
      stage_in[DivInit].rem_b = 32'(num_b[61:31]);
      stage_in[DivInit].dvd_a = num_a[30:0];
      stage_in[DivInit].dvd_b = num_b[30:0];
   end

   // Two dividers side by side, one quotient bit per stage.
   for (genvar k = 0; k < efg_pkg::DivSteps; k++) begin : g_div
      always_comb begin
         efg_pkg::div_type da;
         efg_pkg::div_type db;
         da = efg_pkg::div_step(stage_ff[DivFirst + k - 1].rem_a,
                                stage_ff[DivFirst + k - 1].dvd_a[30],
                                stage_ff[DivFirst + k - 1].l_norm);
         db = efg_pkg::div_step(stage_ff[DivFirst + k - 1].rem_b,
                                stage_ff[DivFirst + k - 1].dvd_b[30],
                                stage_ff[DivFirst + k - 1].l_norm);
         stage_in[DivFirst + k] = stage_ff[DivFirst + k - 1];
         stage_in[DivFirst + k].rem_a = da.rem;
         stage_in[DivFirst + k].rem_b = db.rem;
         stage_in[DivFirst + k].dvd_a = {stage_ff[DivFirst + k - 1].dvd_a[29:0], 1'b0};
         stage_in[DivFirst + k].dvd_b = {stage_ff[DivFirst + k - 1].dvd_b[29:0], 1'b0};
         stage_in[DivFirst + k].q_a = {stage_ff[DivFirst + k - 1].q_a[29:0], da.q};
         stage_in[DivFirst + k].q_b = {stage_ff[DivFirst + k - 1].q_b[29:0], db.q};
      end
   end

   // Saturated length, degenerate test, signs and orientation.
   always_comb begin
      logic [31:0] len;
      logic        degen;
      logic        neg_x;
      logic        neg_y;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      len = stage_ff[Last].ovf ? efg_pkg::LengthMax : stage_ff[Last].s_sq.root[31:0];
      degen = len <= {16'b0, csr_limit};
      neg_x = stage_ff[Last].item.dy_pos ^ stage_ff[Last].flip;
      neg_y = stage_ff[Last].item.dx_neg ^ stage_ff[Last].flip;
      mag_x = {1'b0, stage_ff[Last].q_b};
      mag_y = {1'b0, stage_ff[Last].q_a};
      out_in.edge_length = len;
      out_in.mid_x = stage_ff[Last].item.mid_x;
      out_in.mid_y = stage_ff[Last].item.mid_y;
      out_in.normal_x = degen ? '0 : (neg_x ? -mag_x : mag_x);
      out_in.normal_y = degen ? '0 : (neg_y ? -mag_y : mag_y);
      out_in.degenerate = degen;
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.edge_length = out_ff.edge_length;
   assign rsp_if.mid_x = out_ff.mid_x;
   assign rsp_if.mid_y = out_ff.mid_y;
   assign rsp_if.normal_x = out_ff.normal_x;
   assign rsp_if.normal_y = out_ff.normal_y;
   assign rsp_if.degenerate = out_ff.degenerate;

   // Valid bits of the stages and of the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
         out_valid_ff <= valid_ff[Last];
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NStage; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         out_ff <= out_in;
      end
   end

   `EFG_ASSERT_IMPL(a_degen_zero, rsp_if.valid && rsp_if.degenerate,
      rsp_if.normal_x == '0 && rsp_if.normal_y == '0, "degenerate edge with nonzero normal")
   `EFG_ASSERT_IMPL(a_normal_bound, rsp_if.valid,
      rsp_if.normal_x <= efg_pkg::NormalOne && rsp_if.normal_x >= -efg_pkg::NormalOne
      && rsp_if.normal_y <= efg_pkg::NormalOne && rsp_if.normal_y >= -efg_pkg::NormalOne,
      "normal out of range")

endmodule

// ===== src/edge_face_geometry_2d.sv =====
// Channel  | Direction | Handshake     | Carries
// req_if   | in        | valid / ready | edge endpoints, owner centroid, owner flag
// rsp_if   | out       | valid / ready | length, midpoint, unit normal, degenerate flag
// csr      | in        | write enable  | degenerate limit
//
// One request per cycle sustained while rsp_if.ready holds; a response passes through
// 5 front stages, the queue, 67 back stages (set mostly by the 32-stage
// square root chain and the 31-stage divide chain) and the output register.
// Reset clears the valid bits, credit count, queue pointers and the limit register.
// A stalled response freezes the back pipeline; the front keeps filling the queue
// and drops req_if.ready once in-flight requests reach the queue depth.
module edge_face_geometry_2d #(
   parameter int QUEUE_DEPTH = efg_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   efg_req_if.sink     req_if,
   efg_rsp_if.source   rsp_if,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   logic [15:0]       csr_limit_ff, csr_limit_in;
   logic              push_valid;
   efg_pkg::item_type push_item;
   logic              pop;
   logic              head_valid;
   efg_pkg::item_type head_item;

   // Degenerate limit register.
   assign csr_limit_in = csr_write_enable ? csr_write_data : csr_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_limit_ff <= '0;
      end else begin
         csr_limit_ff <= csr_limit_in;
      end
   end

   // Front: accepts and classifies requests.
   efg_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .pop(pop),
      .push_valid(push_valid),
      .push_item(push_item)
   );

   // Queue between front and back.
   efg_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_item(push_item),
      .pop(pop),
      .head_valid(head_valid),
      .head_item(head_item)
   );

   // Back: square roots, divides and orientation.
   efg_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_item(head_item),
      .csr_limit(csr_limit_ff),
      .pop(pop),
      .rsp_if(rsp_if)
   );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 100;
   localparam int RandomItems = 730;

   typedef struct {
      logic signed [31:0] sx, sy, ex, ey, cx, cy;
      logic               owner;
   } edge_type;

   typedef struct {
      logic [31:0] length;
      logic [31:0] mx, my, nx, ny;
      logic        degen;
   } geom_type;

   typedef struct {
      edge_type e;
      logic     known;
      geom_type g;
   } row_type;

   logic clock;
   logic reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   efg_req_if req_if ();
   efg_rsp_if rsp_if ();

   edge_face_geometry_2d u_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   logic [15:0] limit_q;
   geom_type    expected_q[$];
   int          errors;
   int          idle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   logic        timed_out;

   // The clock runs for the whole simulation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Computes length, midpoint and outward unit normal of one edge.
   function automatic geom_type edge_geometry(edge_type e, logic [15:0] lim);
      geom_type g;
      longint dx, dy, mx, my, rx, ry, nx, ny;
      logic [63:0] adx, ady, a2, s, len, a, b, m, l, qa, qb;
      logic [64:0] s_wide;
      logic [63:0] m1, m2;
      logic n1, n2, neg;
      dx = longint'(e.ex) - longint'(e.sx);
      dy = longint'(e.ey) - longint'(e.sy);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      a2 = adx * adx;
      s_wide = {1'b0, a2} + {1'b0, ady * ady};
      s = s_wide[63:0];
      len = s_wide[64] ? 64'hFFFF_FFFF : isqrt(s);
      mx = (longint'(e.sx) + longint'(e.ex)) >>> 1;
      my = (longint'(e.sy) + longint'(e.ey)) >>> 1;
      nx = 0;
      ny = 0;
      g.degen = len <= {48'd0, lim};
      if (!g.degen) begin
         a = adx;
         b = ady;
         m = adx > ady ? adx : ady;
         while (m < (64'd1 << 30)) begin
            a <<= 1; b <<= 1; m <<= 1;
         end
         while (m >= (64'd1 << 31)) begin
            a >>= 1; b >>= 1; m >>= 1;
         end
         l = isqrt(a * a + b * b);
         qa = ((a << 30) + (l >> 1)) / l;
         qb = ((b << 30) + (l >> 1)) / l;
         nx = dy > 0 ? -longint'(qb) : longint'(qb);
         ny = dx < 0 ? -longint'(qa) : longint'(qa);
         if (e.owner) begin
            rx = mx - longint'(e.cx);
            ry = my - longint'(e.cy);
            m1 = ady * (rx < 0 ? -rx : rx);
            m2 = adx * (ry < 0 ? -ry : ry);
            n1 = dy != 0 && rx != 0 && ((-dy < 0) != (rx < 0));
            n2 = dx != 0 && ry != 0 && ((dx < 0) != (ry < 0));
            if (n1 == n2) neg = n1 && (m1 != 0 || m2 != 0);
            else if (n1) neg = m1 > m2;
            else neg = m2 > m1;
            if (neg) begin
               nx = -nx;
               ny = -ny;
            end
         end
      end
      g.length = len[31:0];
      g.mx = mx[31:0];
      g.my = my[31:0];
      g.nx = nx[31:0];
      g.ny = ny[31:0];
      return g;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // Receiver: random stalls and checking against the oldest expectation.
   always @(posedge clock) begin
      geom_type w;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_if.edge_length, '0);
            end else begin
               w = expected_q.pop_front();
               if (rsp_if.edge_length !== w.length)
                  report_mismatch("edge_length", rsp_if.edge_length, w.length);
               if (rsp_if.mid_x !== w.mx) report_mismatch("mid_x", rsp_if.mid_x, w.mx);
               if (rsp_if.mid_y !== w.my) report_mismatch("mid_y", rsp_if.mid_y, w.my);
               if (rsp_if.normal_x !== w.nx)
                  report_mismatch("normal_x", rsp_if.normal_x, w.nx);
               if (rsp_if.normal_y !== w.ny)
                  report_mismatch("normal_y", rsp_if.normal_y, w.ny);
               if (rsp_if.degenerate !== w.degen)
                  report_mismatch("degenerate", 32'(rsp_if.degenerate), 32'(w.degen));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles in which nothing is accepted.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= WatchdogLimit) begin
         timed_out <= 1'b1;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      idle_count = 0;
      timed_out = 1'b0;
      wait (timed_out);
      $display("status: fail");
      $finish;
   end

   task automatic write_limit(logic [15:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_q = v;
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Offers one request, with a random gap first, and waits for acceptance.
   task automatic send_edge(edge_type e, logic known, geom_type g);
      geom_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.start_x <= e.sx;
      req_if.start_y <= e.sy;
      req_if.end_x <= e.ex;
      req_if.end_y <= e.ey;
      req_if.owner_center_x <= e.cx;
      req_if.owner_center_y <= e.cy;
      req_if.has_owner <= e.owner;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      p = known ? g : edge_geometry(e, limit_q);
      expected_q.insert(expected_q.size(), p);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(4000)) - 2000);
         2: return 32'($signed($urandom_range(2000000)) - 1000000);
         default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
      endcase
   endfunction

   function automatic edge_type rand_edge();
      edge_type e;
      int mode;
      mode = $urandom_range(3);
      e.sx = rand_coord(mode);
      e.sy = rand_coord(mode);
      if ($urandom_range(9) == 0) begin
         e.ex = e.sx + $signed($urandom_range(6)) - 3;
         e.ey = e.sy + $signed($urandom_range(6)) - 3;
      end else begin
         e.ex = rand_coord(mode);
         e.ey = rand_coord(mode);
      end
      if ($urandom_range(3) == 0) begin
         e.cx = (e.sx >>> 1) + (e.ex >>> 1);
         e.cy = (e.sy >>> 1) + (e.ey >>> 1);
      end else begin
         e.cx = rand_coord($urandom_range(3));
         e.cy = rand_coord($urandom_range(3));
      end
      e.owner = $urandom_range(3) != 0;
      return e;
   endfunction

   row_type directed[$];

   // Appends one row to the directed table.
   function automatic void add_row(row_type r);
      directed.insert(directed.size(), r);
   endfunction

   function automatic row_type mk(logic [31:0] sx, sy, ex, ey, cx, cy, logic o);
      row_type r;
      r.e = '{sx, sy, ex, ey, cx, cy, o};
      r.known = 1'b0;
      return r;
   endfunction

   function automatic row_type mk_known(logic [31:0] sx, sy, ex, ey, logic [31:0] len,
                                        logic [31:0] mx, my, nx, ny, logic d);
      row_type r;
      r = mk(sx, sy, ex, ey, 32'd0, 32'd0, 1'b0);
      r.known = 1'b1;
      r.g = '{len, mx, my, nx, ny, d};
      return r;
   endfunction

   initial begin
      row_type r;
      int phase;
      errors = 0;
      limit_q = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.start_x = '0;
      req_if.start_y = '0;
      req_if.end_x = '0;
      req_if.end_y = '0;
      req_if.owner_center_x = '0;
      req_if.owner_center_y = '0;
      req_if.has_owner = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero-length edge after reset is degenerate; unit edges along each axis.
      add_row(mk_known(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      add_row(mk_known(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0000_8000, 0,
                       0, efg_pkg::NormalOne, 1'b0));
      add_row(mk_known(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0000_8000,
                       -efg_pkg::NormalOne, 0, 1'b0));
      add_row(mk_known(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 0, 0, efg_pkg::NormalOne, 1'b0));
      // Length overflow, both directions at the extremes.
      add_row(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 0, 0, 1'b1));
      add_row(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      // Owner on either side, on the edge line, and ignored without an owner.
      add_row(mk(0, 0, 32'h0001_0000, 0, 0, 32'h0000_4000, 1'b1));
      add_row(mk(0, 0, 32'h0001_0000, 0, 0, 32'hFFFF_C000, 1'b1));
      add_row(mk(0, 0, 32'h0001_0000, 0, 32'h0002_0000, 0, 1'b1));
      add_row(mk(0, 0, 32'h0001_0000, 0, 0, 32'h0000_4000, 1'b0));
      add_row(mk(3, 5, -7, -2, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
      add_row(mk(-1, -1, 0, 0, 1, -1, 1'b1));
      add_row(mk(1, 2, 2, 3, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
      foreach (directed[i]) begin
         r = directed[i];
         send_edge(r.e, r.known, r.g);
      end
      req_if.valid <= 1'b0;
      wait_drained();

      // Limit at its top, then edges around it.
      write_limit(16'hFFFF);
      r = mk(0, 0, 32'h0000_FFFF, 0, 0, 0, 1'b0);
      send_edge(r.e, 1'b1, '{32'h0000_FFFF, 32'h0000_7FFF, 0, 0, 0, 1'b1});
      r = mk(0, 0, 32'h0001_0000, 0, 0, 32'h0000_4000, 1'b1);
      send_edge(r.e, 1'b0, '{default: 0});
      r = mk(5, 5, 5 - 32'h0000_B505, 5 + 32'h0000_B505, 9, 9, 1'b1);
      send_edge(r.e, 1'b0, '{default: 0});
      req_if.valid <= 1'b0;
      wait_drained();

      // Random phases over idling patterns and limit settings.
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 59; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 59; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         case (phase)
            0: write_limit(16'd0);
            3: write_limit(16'hFFFF);
            5: write_limit(16'd1);
            default: write_limit(16'($urandom()));
         endcase
         repeat (RandomItems / 8) send_edge(rand_edge(), 1'b0, '{default: 0});
         // Hold off until everything in flight has come back.
         req_if.valid <= 1'b0;
         wait_drained();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/efg_pkg.sv
src/efg_req_if.sv
src/efg_rsp_if.sv
src/efg_front.sv
src/efg_queue.sv
src/efg_back.sv
src/edge_face_geometry_2d.sv
dv/tb.sv
